// ----- rtl/gpc_pkg.sv -----
// gpc_pkg: shared constants, types and helpers of the gop preroll cache
// used by every file of the block; no dependencies
package gpc_pkg;

    localparam int DEPTH    = 32;
    localparam int LEN_BITS = 24;
    localparam int TAG_W    = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int BYTES_W  = 33;
    localparam int CTR_W    = 32;
    localparam int PEAK_U_W = 6;
    localparam int UNITS_W  = 5;
    localparam int PADDR_W  = 4;

    typedef enum logic [1:0] {
        FN_PUSH   = 2'd0,
        FN_REPLAY = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STAT_STORED   = 3'd0,
        STAT_SKIPPED  = 3'd1,
        STAT_OVERFLOW = 3'd2,
        STAT_ENTRY    = 3'd3,
        STAT_EMPTY    = 3'd4,
        STAT_CLEARED  = 3'd5
    } status_t;

    localparam logic [1:0] REG_MAX_UNITS = 2'd0;
    localparam logic [1:0] REG_MAX_BYTES = 2'd1;
    localparam logic [1:0] REG_SRC_VIDEO = 2'd2;

    typedef struct packed {
        logic [4:0]  unit_limit;
        logic [31:0] byte_limit;
        logic        video_src;
    } cfg_t;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [LEN_BITS-1:0] len;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

// ----- rtl/gpc_if.sv -----
// gpc_if: valid/ready channel interfaces for request and result items
// depends on gpc_pkg
interface gpc_in_if;
    import gpc_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic                is_video;
    logic                is_keyframe;
    logic [LEN_BITS-1:0] payload_len;
    logic [TAG_W-1:0]    frame_tag;

    modport source (output valid, func, is_video, is_keyframe, payload_len, frame_tag,
                    input ready);
    modport sink   (input valid, func, is_video, is_keyframe, payload_len, frame_tag,
                    output ready);
endinterface

interface gpc_out_if;
    import gpc_pkg::*;
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [TAG_W-1:0]    out_tag;
    logic [LEN_BITS-1:0] out_len;
    logic                last;
    logic [UNITS_W-1:0]  units_held;
    logic [31:0]         bytes_held;
    logic                ready_res;
    logic [CTR_W-1:0]    overflow_count;
    logic [CTR_W-1:0]    unit_overflow_count;
    logic [CTR_W-1:0]    byte_overflow_count;
    logic [PEAK_U_W-1:0] peak_units;
    logic [BYTES_W-1:0]  peak_bytes;

    modport source (output valid, status, out_tag, out_len, last, units_held, bytes_held,
                    ready_res, overflow_count, unit_overflow_count,
                    byte_overflow_count, peak_units, peak_bytes,
                    input ready);
    modport sink   (input valid, status, out_tag, out_len, last, units_held, bytes_held,
                    ready_res, overflow_count, unit_overflow_count,
                    byte_overflow_count, peak_units, peak_bytes,
                    output ready);
endinterface

// ----- rtl/gop_preroll_cache_core.sv -----
// gop_preroll_cache_core: top level, config registers, control and ring storage
// depends on gpc_pkg, gpc_if, gpc_slots, gpc_ctrl
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        func, is_video, is_keyframe, payload_len, frame_tag
//   res      out  valid/ready        status, out_tag, out_len, last, statistics
//   apb      in   psel/penable       paddr, pwdata, pwrite -> prdata, pready
//
// push, clear and empty replay: one result per item; an item is taken when no result waits or res.ready is high
// replay of n held frames: n results, one ring read per cycle on the single read port unless a result stalls
// no new item is taken during a replay; a waiting result only stalls while res.ready is low
// reset clears all pointers, counts and statistics at once; ring contents need no clearing
module gop_preroll_cache_core
    import gpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    gpc_in_if.sink             req,
    gpc_out_if.source          res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t       cfg_reg;
    ram_req_t   ram_req;
    entry_t     ram_rdata;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_limit <= 5'd31;
            cfg_reg.byte_limit <= 32'd1048576;
            cfg_reg.video_src  <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAX_UNITS: cfg_reg.unit_limit <= pwdata[4:0];
                REG_MAX_BYTES: cfg_reg.byte_limit <= pwdata;
                REG_SRC_VIDEO: cfg_reg.video_src  <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MAX_UNITS: prdata = 32'(cfg_reg.unit_limit);
            REG_MAX_BYTES: prdata = cfg_reg.byte_limit;
            REG_SRC_VIDEO: prdata = 32'(cfg_reg.video_src);
            default:       prdata = '0;
        endcase
    end

    gpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    gpc_slots u_slots (
        .clk     (clk),
        .ram_req (ram_req),
        .rd_data (ram_rdata)
    );

endmodule

// ----- rtl/gpc_slots.sv -----
// gpc_slots: descriptor ring storage, one write and one registered read port
// depends on gpc_pkg
module gpc_slots
    import gpc_pkg::*;
(
    input  logic     clk,
    input  ram_req_t ram_req,
    output entry_t   rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ram_req.wr_en)
        begin
            mem[ram_req.wr_addr] <= ram_req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_req.rd_en)
        begin
            rd_data_reg <= mem[ram_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/gpc_ctrl.sv -----
// gpc_ctrl: ring pointers, push/replay/clear sequencing, statistics, result register
// depends on gpc_pkg, gpc_if and the ring storage in gpc_slots
module gpc_ctrl
    import gpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    gpc_in_if.sink        req,
    gpc_out_if.source     res,
    output ram_req_t      ram_req,
    input  entry_t        ram_rdata
);

    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REPLAY = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    wi_reg, wi_next;
    logic [CNT_W-1:0]     hc_reg, hc_next;
    logic [BYTES_W-1:0]   hb_reg, hb_next;
    logic                 bo_reg, bo_next;
    logic [CTR_W-1:0]     ovf_all_reg, ovf_all_next;
    logic [CTR_W-1:0]     ovf_unit_reg, ovf_unit_next;
    logic [CTR_W-1:0]     ovf_byte_reg, ovf_byte_next;
    logic [PEAK_U_W-1:0]  peak_u_reg, peak_u_next;
    logic [BYTES_W-1:0]   peak_b_reg, peak_b_next;
    logic [ADDR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [TAG_W-1:0]     out_tag_reg, out_tag_next;
    logic [LEN_BITS-1:0]  out_len_reg, out_len_next;
    logic                 out_last_reg, out_last_next;
    logic [UNITS_W-1:0]   out_units_reg, out_units_next;
    logic [31:0]          out_bytes_reg, out_bytes_next;
    logic                 out_rdy_reg, out_rdy_next;

    logic                 out_free;
    logic                 accept;
    logic                 load;

    // push evaluation
    logic [ADDR_W-1:0]    p_wi;
    logic [CNT_W-1:0]     p_hc;
    logic [BYTES_W-1:0]   p_hb;
    logic                 p_bo;
    logic [CTR_W-1:0]     p_ovf_all, p_ovf_unit, p_ovf_byte;
    logic [PEAK_U_W-1:0]  p_peak_u;
    logic [BYTES_W-1:0]   p_peak_b;
    logic                 p_wr;
    logic [ADDR_W-1:0]    p_wr_addr;
    status_t              p_status;

    logic [SUM_W-1:0]     start_wide;
    logic [ADDR_W-1:0]    start_addr;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free  = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        logic [ADDR_W-1:0]  wi_b;
        logic [CNT_W-1:0]   hc_b;
        logic [BYTES_W-1:0] hb_b;
        logic               bo_b;
        logic               skip;
        logic               full;
        logic [CNT_W-1:0]   hc_inc;
        logic [BYTES_W-1:0] hb_sum;
        logic               over_u;
        logic               over_b;

        wi_b   = wi_reg;
        hc_b   = hc_reg;
        hb_b   = hb_reg;
        bo_b   = bo_reg;
        skip   = 1'b0;

        if (req.is_video)
        begin
            if (req.is_keyframe)
            begin
                wi_b = '0;
                hc_b = '0;
                hb_b = '0;
                bo_b = 1'b1;
            end
            else if (!bo_reg)
            begin
                skip = 1'b1;
            end
        end
        else if (!bo_reg)
        begin
            if (cfg.video_src)
            begin
                skip = 1'b1;
            end
            else
            begin
                bo_b = 1'b1;
            end
        end

        full   = (hc_b >= CNT_W'(DEPTH));
        hc_inc = hc_b + 1'b1;
        hb_sum = hb_b + BYTES_W'(req.payload_len);
        over_u = (8'(hc_inc) > 8'(cfg.unit_limit));
        over_b = (hb_sum > BYTES_W'(cfg.byte_limit));

        p_wi       = wi_reg;
        p_hc       = hc_reg;
        p_hb       = hb_reg;
        p_bo       = bo_reg;
        p_ovf_all  = ovf_all_reg;
        p_ovf_unit = ovf_unit_reg;
        p_ovf_byte = ovf_byte_reg;
        p_peak_u   = peak_u_reg;
        p_peak_b   = peak_b_reg;
        p_wr       = 1'b0;
        p_wr_addr  = wi_b;
        p_status   = STAT_SKIPPED;

        if (!skip)
        begin
            if (full)
            begin
                p_ovf_all  = sat_inc(ovf_all_reg);
                p_ovf_unit = sat_inc(ovf_unit_reg);
                p_wi       = '0;
                p_hc       = '0;
                p_hb       = '0;
                p_bo       = 1'b0;
                p_status   = STAT_OVERFLOW;
            end
            else
            begin
                p_wr = 1'b0;
                if (8'(hc_inc) > 8'(peak_u_reg))
                begin
                    p_peak_u = PEAK_U_W'(hc_inc);
                end
                if (hb_sum > peak_b_reg)
                begin
                    p_peak_b = hb_sum;
                end
                if (over_u || over_b)
                begin
                    p_ovf_all = sat_inc(ovf_all_reg);
                    if (over_u)
                    begin
                        p_ovf_unit = sat_inc(ovf_unit_reg);
                    end
                    if (over_b)
                    begin
                        p_ovf_byte = sat_inc(ovf_byte_reg);
                    end
                    p_wi     = '0;
                    p_hc     = '0;
                    p_hb     = '0;
                    p_bo     = 1'b0;
                    p_status = STAT_OVERFLOW;
                end
                else
                begin
                    p_wr     = 1'b1;
                    p_wi     = ptr_inc(wi_b);
                    p_hc     = hc_inc;
                    p_hb     = hb_sum;
                    p_bo     = bo_b;
                    p_status = STAT_STORED;
                end
            end
        end
    end

    // oldest held entry
    always_comb
    begin
        start_wide = SUM_W'(wi_reg) - SUM_W'(hc_reg);
        if (hc_reg > CNT_W'(wi_reg))
        begin
            start_wide = SUM_W'(wi_reg) + SUM_W'(DEPTH) - SUM_W'(hc_reg);
        end
        start_addr = start_wide[ADDR_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        wi_next         = wi_reg;
        hc_next         = hc_reg;
        hb_next         = hb_reg;
        bo_next         = bo_reg;
        ovf_all_next    = ovf_all_reg;
        ovf_unit_next   = ovf_unit_reg;
        ovf_byte_next   = ovf_byte_reg;
        peak_u_next     = peak_u_reg;
        peak_b_next     = peak_b_reg;
        rd_ptr_next     = rd_ptr_reg;
        rem_next        = rem_reg;
        load            = 1'b0;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        ram_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_tag_next  = '0;
                    out_len_next  = '0;
                    out_last_next = 1'b1;
                    unique case (req.func)
                        FN_PUSH:
                        begin
                            load            = 1'b1;
                            out_status_next = p_status;
                            wi_next         = p_wi;
                            hc_next         = p_hc;
                            hb_next         = p_hb;
                            bo_next         = p_bo;
                            ovf_all_next    = p_ovf_all;
                            ovf_unit_next   = p_ovf_unit;
                            ovf_byte_next   = p_ovf_byte;
                            peak_u_next     = p_peak_u;
                            peak_b_next     = p_peak_b;
                            ram_req.wr_en   = p_wr;
                            ram_req.wr_addr = p_wr_addr;
                            ram_req.wr_data = '{tag: req.frame_tag, len: req.payload_len};
                        end
                        FN_REPLAY:
                        begin
                            if (hc_reg == '0)
                            begin
                                load            = 1'b1;
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = start_addr;
                                rd_ptr_next     = ptr_inc(start_addr);
                                rem_next        = hc_reg;
                                state_next      = ST_REPLAY;
                            end
                        end
                        FN_CLEAR:
                        begin
                            load            = 1'b1;
                            out_status_next = STAT_CLEARED;
                            wi_next         = '0;
                            hc_next         = '0;
                            hb_next         = '0;
                            bo_next         = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_REPLAY:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    out_status_next = STAT_ENTRY;
                    out_tag_next    = ram_rdata.tag;
                    out_len_next    = ram_rdata.len;
                    out_last_next   = (rem_reg == CNT_W'(1));
                    rem_next        = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = rd_ptr_reg;
                        rd_ptr_next     = ptr_inc(rd_ptr_reg);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_units_next = UNITS_W'(hc_next);
        out_bytes_next = hb_next[31:0];
        out_rdy_next   = bo_next && (hc_next != '0);
        out_valid_next = load ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wi_reg        <= '0;
            hc_reg        <= '0;
            hb_reg        <= '0;
            bo_reg        <= 1'b0;
            ovf_all_reg   <= '0;
            ovf_unit_reg  <= '0;
            ovf_byte_reg  <= '0;
            peak_u_reg    <= '0;
            peak_b_reg    <= '0;
            rd_ptr_reg    <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wi_reg        <= wi_next;
            hc_reg        <= hc_next;
            hb_reg        <= hb_next;
            bo_reg        <= bo_next;
            ovf_all_reg   <= ovf_all_next;
            ovf_unit_reg  <= ovf_unit_next;
            ovf_byte_reg  <= ovf_byte_next;
            peak_u_reg    <= peak_u_next;
            peak_b_reg    <= peak_b_next;
            rd_ptr_reg    <= rd_ptr_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= out_status_next;
            out_tag_reg    <= out_tag_next;
            out_len_reg    <= out_len_next;
            out_last_reg   <= out_last_next;
            out_units_reg  <= out_units_next;
            out_bytes_reg  <= out_bytes_next;
            out_rdy_reg    <= out_rdy_next;
        end
    end

    // counters and peaks only move with a pushed item, so the result copies the live values
    assign res.valid               = out_valid_reg;
    assign res.status              = out_status_reg;
    assign res.out_tag             = out_tag_reg;
    assign res.out_len             = out_len_reg;
    assign res.last                = out_last_reg;
    assign res.units_held          = out_units_reg;
    assign res.bytes_held          = out_bytes_reg;
    assign res.ready_res           = out_rdy_reg;
    assign res.overflow_count      = ovf_all_reg;
    assign res.unit_overflow_count = ovf_unit_reg;
    assign res.byte_overflow_count = ovf_byte_reg;
    assign res.peak_units          = peak_u_reg;
    assign res.peak_bytes          = peak_b_reg;

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hc_reg <= CNT_W'(DEPTH))
        else $error("held count beyond ring depth");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !bo_reg |-> hc_reg == '0)
        else $error("frames held with no boundary open");

    a_replay_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPLAY |-> rem_reg != '0)
        else $error("replay with nothing left");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status != STAT_ENTRY |-> res.last)
        else $error("single result without last");

endmodule
